// ===== rtl/acr_pkg.sv =====
// Shared constants and codes for the area connectivity reachability block.
package acr_pkg;

    localparam int MAX_EDGES = 64;
    localparam int NUM_AREAS = 64;

    localparam int AREA_W = 6;
    localparam int EDGE_W = 2 * AREA_W;
    localparam int MASK_W = 64;
    localparam int TOTAL_W = 7;
    localparam int ADDR_W = $clog2(MAX_EDGES);
    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;

endpackage

// ===== rtl/acr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/area_connectivity_reachability.sv =====
// Top level: edge table upkeep and reachability closure over stored area edges.
//
// Input channel (i_in_valid / o_in_stall) carries one command transaction:
// opcode (add, remove, query), an edge area_a -> area_b and the root area.
// Output channel (o_out_valid / i_out_stall) returns one transaction per
// command: the mask of areas connected to the root, the edge count and a status.
// Edges live in a RAM of MAX_EDGES entries; one read port feeds a single
// compare/merge step under a small sequencer, one stored edge per cycle.
// A remove scans the stored entries in order until one matches. Each closure
// pass scans every stored edge; passes repeat until the mask stops growing,
// at most NUM_AREAS of them.
// The block takes one command at a time: o_in_stall is high from acceptance
// until the result is loaded into the output register. A result waiting there
// does not block the next command; a new result waits while i_out_stall holds.
// Reset (synchronous, active low) empties the table and clears the output.
module area_connectivity_reachability
    import acr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [AREA_W-1:0]   i_area_a,
    input  logic [AREA_W-1:0]   i_area_b,
    input  logic [AREA_W-1:0]   i_root_area,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [MASK_W-1:0]   o_reach_mask,
    output logic [TOTAL_W-1:0]  o_edge_total,
    output logic [1:0]          o_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_RM_RD,
        S_RM_CHK,
        S_RM_MVRD,
        S_RM_MV,
        S_CL_INIT,
        S_CL_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [AREA_W-1:0]  r_a, n_a;
    logic [AREA_W-1:0]  r_b, n_b;
    logic [AREA_W-1:0]  r_root, n_root;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [1:0]         r_status, n_status;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic               r_vld, n_vld;
    logic               r_grew, n_grew;
    logic               r_out_valid, n_out_valid;
    logic [MASK_W-1:0]  r_out_mask, n_out_mask;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic [1:0]         r_out_status, n_out_status;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [EDGE_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [EDGE_W-1:0]  rd_data;

    logic [AREA_W-1:0]  edge_a;
    logic [AREA_W-1:0]  edge_b;
    logic [CNT_W-1:0]   count_m1;
    logic               issue;
    logic               in_acc;

    acr_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign edge_a   = rd_data[EDGE_W-1:AREA_W];
    assign edge_b   = rd_data[AREA_W-1:0];
    assign count_m1 = r_count - 1'b1;
    assign issue    = (r_k < r_count);
    assign in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_root       = r_root;
        n_count      = r_count;
        n_k          = r_k;
        n_status     = r_status;
        n_mask       = r_mask;
        n_vld        = 1'b0;
        n_grew       = r_grew;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_mask   = r_out_mask;
        n_out_total  = r_out_total;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_addr      = r_count[ADDR_W-1:0];
        wr_data      = {r_a, r_b};
        rd_addr      = r_k[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_a      = i_area_a;
                    n_b      = i_area_b;
                    n_root   = i_root_area;
                    n_status = ST_OK;
                    n_k      = '0;
                    priority if (i_opcode == OP_ADD) begin
                        n_state = S_ADD;
                    end else if (i_opcode == OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = ST_NO_MATCH;
                            n_state  = S_CL_INIT;
                        end else begin
                            n_state = S_RM_RD;
                        end
                    end else begin
                        n_state = S_CL_INIT;
                    end
                end
            end
            S_ADD: begin
                if (r_count >= CNT_W'(MAX_EDGES)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_state = S_CL_INIT;
            end
            S_RM_RD: begin
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                if (edge_a == r_a && edge_b == r_b) begin
                    n_state = S_RM_MVRD;
                end else if (r_k + 1'b1 == r_count) begin
                    n_status = ST_NO_MATCH;
                    n_state  = S_CL_INIT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RM_RD;
                end
            end
            S_RM_MVRD: begin
                rd_addr = count_m1[ADDR_W-1:0];
                n_state = S_RM_MV;
            end
            S_RM_MV: begin
                // last entry moves into the freed slot
                wr_en   = 1'b1;
                wr_addr = r_k[ADDR_W-1:0];
                wr_data = rd_data;
                n_count = count_m1;
                n_state = S_CL_INIT;
            end
            S_CL_INIT: begin
                n_k    = '0;
                n_grew = 1'b0;
                n_mask = '0;
                if ({1'b0, r_root} < (AREA_W + 1)'(NUM_AREAS)) begin
                    n_mask[r_root] = 1'b1;
                    n_state = (r_count == '0) ? S_DONE : S_CL_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CL_SCAN: begin
                if (issue) begin
                    n_vld = 1'b1;
                    n_k   = r_k + 1'b1;
                end
                if (r_vld) begin
                    if ({1'b0, edge_a} < (AREA_W + 1)'(NUM_AREAS) &&
                        {1'b0, edge_b} < (AREA_W + 1)'(NUM_AREAS) &&
                        (r_mask[edge_a] || r_mask[edge_b]) &&
                        !(r_mask[edge_a] && r_mask[edge_b])) begin
                        n_mask[edge_a] = 1'b1;
                        n_mask[edge_b] = 1'b1;
                        n_grew = 1'b1;
                    end
                end else if (!issue) begin
                    if (r_grew) begin
                        n_k    = '0;
                        n_grew = 1'b0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_mask   = r_mask;
                    n_out_total  = TOTAL_W'(r_count);
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_vld       <= 1'b0;
            r_grew      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_mask  <= '0;
            r_out_total <= '0;
            r_out_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_vld        <= n_vld;
            r_grew       <= n_grew;
            r_out_valid  <= n_out_valid;
            r_out_mask   <= n_out_mask;
            r_out_total  <= n_out_total;
            r_out_status <= n_out_status;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_root   <= n_root;
        r_k      <= n_k;
        r_status <= n_status;
        r_mask   <= n_mask;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_reach_mask = r_out_mask;
    assign o_edge_total = r_out_total;
    assign o_status     = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EDGES))
        else $error("edge count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1 ||
                            r_count == $past(r_count) - 1'b1))
        else $error("edge count moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_edge_total == TOTAL_W'(MAX_EDGES))
        else $error("full status with table not full");

endmodule

// ===== test/tb_top.sv =====
// Testbench for area_connectivity_reachability: queued command driver, result monitor, predictor.
module tb_top
    import acr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int ITEMS = 650;
    localparam int IDLE_PCT = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [AREA_W-1:0] a;
        logic [AREA_W-1:0] b;
        logic [AREA_W-1:0] root;
    } cmd_t;

    typedef struct packed {
        logic [MAX_EDGES-1:0][EDGE_W-1:0] pairs;
        logic [CNT_W-1:0]                 count;
        logic [1:0]                       status;
    } edge_list_t;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         status;
    } reach_report_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_opcode = '0;
    logic [AREA_W-1:0]   i_area_a = '0;
    logic [AREA_W-1:0]   i_area_b = '0;
    logic [AREA_W-1:0]   i_root_area = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [MASK_W-1:0]   o_reach_mask;
    logic [TOTAL_W-1:0]  o_edge_total;
    logic [1:0]          o_status;

    cmd_t          cmd_q[$];
    reach_report_t reach_due[$];
    edge_list_t    edge_model = '0;
    edge_list_t    gen_list = '0;
    logic          in_taken = 1'b0;
    logic          steady;
    int            n_issued = 0;
    int            n_in_done = 0;
    int            n_out_done = 0;
    int            n_errors = 0;
    int            hold_left = 0;
    int            holds_done = 0;
    int            dead_cycles = 0;
    int            win_lo = 0;
    int            win_span = NUM_AREAS;
    int            n_add = 0, n_remove = 0, n_query = 0;
    int            n_full = 0, n_unmatched = 0, widest = 0;

    area_connectivity_reachability i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_area_a    (i_area_a),
        .i_area_b    (i_area_b),
        .i_root_area (i_root_area),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_reach_mask(o_reach_mask),
        .o_edge_total(o_edge_total),
        .o_status    (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    assign steady = (n_in_done >= 250) && (n_in_done < 350);

    function automatic edge_list_t apply_edit(edge_list_t s, cmd_t c);
        int k;
        s.status = ST_OK;
        if (c.op == OP_ADD) begin
            if (s.count >= MAX_EDGES) begin
                s.status = ST_FULL;
            end else begin
                s.pairs[s.count] = {c.a, c.b};
                s.count++;
            end
        end else if (c.op == OP_REMOVE) begin
            s.status = ST_NO_MATCH;
            for (k = 0; k < s.count; k++) begin
                if (s.pairs[k] == {c.a, c.b}) begin
                    s.count--;
                    s.pairs[k] = s.pairs[s.count];
                    s.status = ST_OK;
                    break;
                end
            end
        end
        return s;
    endfunction

    function automatic logic [MASK_W-1:0] reach_from(edge_list_t s, logic [AREA_W-1:0] root);
        logic [MASK_W-1:0] m;
        logic [MASK_W-1:0] ends;
        logic [AREA_W-1:0] ea;
        logic [AREA_W-1:0] eb;
        int pass;
        int k;
        bit grew;
        if (root >= NUM_AREAS) return '0;
        m = '0;
        m[root] = 1'b1;
        for (pass = 0; pass < NUM_AREAS; pass++) begin
            grew = 1'b0;
            for (k = 0; k < s.count; k++) begin
                {ea, eb} = s.pairs[k];
                if (ea < NUM_AREAS && eb < NUM_AREAS) begin
                    ends = '0;
                    ends[ea] = 1'b1;
                    ends[eb] = 1'b1;
                    if ((m & ends) != '0 && (m & ends) != ends) begin
                        m |= ends;
                        grew = 1'b1;
                    end
                end
            end
            if (!grew) break;
        end
        return m;
    endfunction

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic int rand_area();
        return (win_lo + $urandom_range(win_span - 1)) % NUM_AREAS;
    endfunction

    // root is either anywhere or an endpoint of a stored edge
    function automatic int any_root();
        int idx;
        if (gen_list.count == 0 || $urandom_range(1) == 0) return $urandom_range(NUM_AREAS - 1);
        idx = $urandom_range(gen_list.count - 1);
        return $urandom_range(1) ? int'(gen_list.pairs[idx][EDGE_W-1:AREA_W])
                                 : int'(gen_list.pairs[idx][AREA_W-1:0]);
    endfunction

    task automatic issue(input logic [1:0] op, input int a, input int b, input int root);
        cmd_t c;
        c.op = op;
        c.a = a[AREA_W-1:0];
        c.b = b[AREA_W-1:0];
        c.root = root[AREA_W-1:0];
        cmd_q.push_back(c);
        gen_list = apply_edit(gen_list, c);
        n_issued++;
    endtask

    task automatic remove_stored();
        int idx;
        idx = $urandom_range(gen_list.count - 1);
        issue(OP_REMOVE, int'(gen_list.pairs[idx][EDGE_W-1:AREA_W]),
              int'(gen_list.pairs[idx][AREA_W-1:0]), any_root());
    endtask

    task automatic drain_table();
        while (gen_list.count != 0) remove_stored();
        issue(OP_REMOVE, rand_area(), rand_area(), any_root());
    endtask

    task automatic flag(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            flag($sformatf("result %0d %s: expected %h, got %h", n_out_done, name, want, got));
    endtask

    // driver: new transaction only when the line is empty or the last one was taken
    always @(negedge i_clk) begin : drive
        cmd_t c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (cmd_q.size() == 0 || idle_roll()) begin
                i_in_valid <= 1'b0;
            end else begin
                c = cmd_q.pop_front();
                i_in_valid <= 1'b1;
                i_opcode <= c.op;
                i_area_a <= c.a;
                i_area_b <= c.b;
                i_root_area <= c.root;
            end
        end
    end

    always @(negedge i_clk) begin : receive
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_done < 2 && n_in_done >= (holds_done == 0 ? 120 : 480)) begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_roll();
        end
    end

    always @(posedge i_clk) begin : observe
        reach_report_t got;
        reach_report_t want;
        reach_report_t fresh;
        cmd_t c;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_reach_mask, o_edge_total, o_status};
                if (reach_due.size() == 0) begin
                    flag($sformatf("result %0d arrived with nothing outstanding", n_out_done));
                end else begin
                    want = reach_due.pop_front();
                    check_field("reach_mask", got.mask, want.mask);
                    check_field("edge_total", 64'(got.total), 64'(want.total));
                    check_field("status", 64'(got.status), 64'(want.status));
                end
                n_out_done++;
            end
            if (i_in_valid && !o_in_stall) begin
                c = {i_opcode, i_area_a, i_area_b, i_root_area};
                edge_model = apply_edit(edge_model, c);
                fresh.mask = reach_from(edge_model, c.root);
                fresh.total = edge_model.count[TOTAL_W-1:0];
                fresh.status = edge_model.status;
                reach_due.push_back(fresh);
                n_in_done++;
                if (c.op == OP_ADD) n_add++;
                else if (c.op == OP_REMOVE) n_remove++;
                else n_query++;
                if (fresh.status == ST_FULL) n_full++;
                if (fresh.status == ST_NO_MATCH) n_unmatched++;
                if ($countones(fresh.mask) > widest) widest = $countones(fresh.mask);
            end
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL area_connectivity_reachability");
            $finish;
        end
    end

    initial begin : run
        int kind;
        int n;
        int k;
        int idx;
        int len;
        int tmp;
        int n_fills;
        int n_long_chains;
        int order[NUM_AREAS];
        n_fills = 0;
        n_long_chains = 0;

        // directed: empty table, self loop, duplicates, reversed pair, swap-with-last
        issue(OP_QUERY, 0, 0, 0);
        issue(OP_REMOVE, 5, 9, 5);
        issue(OP_SPARE, 63, 63, 63);
        issue(OP_ADD, 0, 63, 63);
        issue(OP_ADD, 63, 63, 0);
        issue(OP_ADD, 0, 63, 17);
        issue(OP_REMOVE, 63, 0, 0);
        issue(OP_ADD, 42, 21, 21);
        issue(OP_REMOVE, 0, 63, 42);
        issue(OP_REMOVE, 0, 63, 0);
        issue(OP_REMOVE, 0, 63, 0);
        for (k = 0; k < 5; k++) issue(OP_ADD, 1 << k, 2 << k, 32);
        issue(OP_SPARE, 21, 42, 1);
        issue(OP_QUERY, 63, 0, 21);

        while (n_issued < ITEMS) begin
            kind = $urandom_range(99);
            if (n_fills == 0) kind = 0;
            if (n_long_chains == 0 && n_issued > 300) kind = 99;
            win_lo = $urandom_range(NUM_AREAS - 1);
            win_span = ($urandom_range(3) == 0) ? NUM_AREAS : $urandom_range(16, 4);
            if (kind < 10) begin
                while (gen_list.count < MAX_EDGES)
                    issue(OP_ADD, rand_area(), rand_area(), any_root());
                n = $urandom_range(3, 1);
                for (k = 0; k < n; k++) issue(OP_ADD, rand_area(), rand_area(), any_root());
                n_fills++;
            end else if (kind < 40) begin
                n = $urandom_range(12, 1);
                for (k = 0; k < n; k++) issue(OP_ADD, rand_area(), rand_area(), any_root());
            end else if (kind < 65) begin
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++) begin
                    if (gen_list.count != 0) remove_stored();
                    else issue(OP_REMOVE, rand_area(), rand_area(), any_root());
                end
            end else if (kind < 75) begin
                if (gen_list.count != 0 && $urandom_range(1) == 1) begin
                    idx = $urandom_range(gen_list.count - 1);
                    issue(OP_REMOVE, int'(gen_list.pairs[idx][AREA_W-1:0]),
                          int'(gen_list.pairs[idx][EDGE_W-1:AREA_W]), any_root());
                end else begin
                    issue(OP_REMOVE, rand_area(), rand_area(), any_root());
                end
            end else if (kind < 85) begin
                issue($urandom_range(1) ? OP_QUERY : OP_SPARE, $urandom_range(NUM_AREAS - 1),
                      $urandom_range(NUM_AREAS - 1), any_root());
            end else if (kind < 92) begin
                drain_table();
                issue(OP_QUERY, rand_area(), rand_area(), any_root());
            end else begin
                // chain stored back to front: one new area per closure pass
                len = (n_long_chains < 2) ? NUM_AREAS - 1 : $urandom_range(15, 3);
                if (len == NUM_AREAS - 1) begin
                    drain_table();
                    n_long_chains++;
                end
                for (k = 0; k < NUM_AREAS; k++) order[k] = k;
                for (k = NUM_AREAS - 1; k > 0; k--) begin
                    idx = $urandom_range(k);
                    tmp = order[k];
                    order[k] = order[idx];
                    order[idx] = tmp;
                end
                for (k = len - 1; k >= 0; k--)
                    if (gen_list.count < MAX_EDGES)
                        issue(OP_ADD, order[k], order[k + 1], any_root());
                issue(OP_QUERY, rand_area(), rand_area(), order[0]);
                issue(OP_SPARE, rand_area(), rand_area(), order[len]);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_in_done < n_issued) @(posedge i_clk);
        while (reach_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (reach_due.size() != 0) flag($sformatf("%0d results never arrived", reach_due.size()));

        $display("%0d commands: %0d adds, %0d removes, %0d queries; %0d results checked",
                 n_in_done, n_add, n_remove, n_query, n_out_done);
        $display("full-table drops %0d, unmatched removes %0d, largest reach set %0d areas",
                 n_full, n_unmatched, widest);
        $display("%0d errors", n_errors);
        if (n_errors == 0) begin
            $display("PASS area_connectivity_reachability");
        end else begin
            $display("FAIL area_connectivity_reachability");
        end
        $finish;
    end

endmodule
